// ----- sv/dwpid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid_pkg: shared constants and types
// Widths, register indexes and reset values of the wheel speed drive.
// ----------------------------------------------------------------------------
package dwpid_pkg;
	localparam int TICK_BITS_DEF = 24;
	localparam int WHEELS_DEF    = 2;
	localparam int POWER_MAX     = 25600;
	localparam int MS_PER_S      = 1000;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DPT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SKID   = 3'd6;

	localparam logic signed [15:0] TARGET_RST = 16'sd2560;
	localparam logic [15:0] GAIN_P_RST = 16'd3686;
	localparam logic [15:0] GAIN_I_RST = 16'd369;
	localparam logic [15:0] GAIN_D_RST = 16'd1638;
	localparam logic [15:0] DPT_RST    = 16'd1024;

	// divider width: numerator is |delta| * dpt * 1000 (TICK_BITS+1+16+10 bits)
	localparam int DIV_W = 64;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ----- sv/dual_wheel_pid_speed_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_drive: two-wheel incremental PID speed controller
// Per sample: speed from tick delta over elapsed ms, error vs target, PID
// increment added to each wheel's power, with run-distance cutoff.
// ----------------------------------------------------------------------------
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------
//  in      | action left_ticks right_ticks time_ms    | in_valid/in_stall
//  out     | left_drive right_drive done_res time_fault | out_valid/out_stall
//  cfg     | cfg_index cfg_data                       | cfg_valid/cfg_ready
//
//  One item at a time. Start and distance-done items set the output register
//  at the input transfer; a zero-dt sample passes through ST_OUT. A control
//  sample runs, per wheel, a shift-add |delta|*dpt product, a bit-serial
//  divide for speed and three shift-add products (P, I, D terms), each with
//  a handoff state, then ST_OUT. Reset restores register defaults and clears
//  wheel state. A result waits in the output register while stalled; the
//  next item is taken once that register is free.
// ----------------------------------------------------------------------------
module dual_wheel_pid_speed_drive #(
	parameter int TICK_BITS = dwpid_pkg::TICK_BITS_DEF,
	parameter int WHEELS    = dwpid_pkg::WHEELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [23:0]                       left_ticks,
	input  logic [23:0]                       right_ticks,
	input  logic [31:0]                       time_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                left_drive,
	output logic signed [15:0]                right_drive,
	output logic                              done_res,
	output logic                              time_fault,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dwpid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [23:0]                       cfg_data
);
	localparam int DW = dwpid_pkg::DIV_W;
	localparam int WIX = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int PAW = 34;   // signed multiplicand width for PID terms
	localparam int TW  = TICK_BITS + 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DPT   = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_ERR   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_UPD   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [15:0] target_q;
	logic [15:0] gain_p_q, gain_i_q, gain_d_q, dpt_q;
	logic [23:0] limit_q;
	logic skid_q;

	// wheel state
	logic signed [15:0] power_q [WHEELS];
	logic signed [15:0] perr_q  [WHEELS];
	logic signed [31:0] esum_q  [WHEELS];
	logic [TICK_BITS-1:0] pticks_q [WHEELS];
	logic [31:0] ptime_q;

	// item registers
	logic [TICK_BITS-1:0] ticks_q [2];
	logic [31:0] now_q, dt_q;
	logic [WIX-1:0] w_q;
	logic [1:0] term_q;
	logic neg_q;
	logic signed [TW-1:0] delta_q;
	logic signed [15:0] err_q;
	logic signed [31:0] sum_q;
	logic signed [PAW+15:0] acc_q;

	// output register
	logic out_full_q;
	logic signed [15:0] ldrv_q, rdrv_q;
	logic done_q, fault_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE) || out_full_q;
	assign out_valid = out_full_q;
	assign left_drive  = ldrv_q;
	assign right_drive = rdrv_q;
	assign done_res    = done_q;
	assign time_fault  = fault_q;

	logic in_xfer, out_xfer;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_full_q && !out_stall;

	// shared multiplier: |delta|*dpt product in ST_DPT, PID terms in ST_ERR and ST_MUL
	logic mul_start, mul_done;
	logic signed [PAW-1:0] mul_a;
	logic [15:0] mul_b;
	logic signed [PAW+15:0] mul_p;

	// divider
	logic div_start;
	logic [DW-1:0] div_num, div_quo;
	dwpid_pkg::div_ctl_t div_ctl;

	// |delta| * dpt * 1000 formed by multiplier on |delta| and dpt*1000 split
	// into two passes would cost more; instead |delta|*dpt first, then *1000
	// by shift-add constant (x1024 - x16 - x8).
	logic [TW+15:0] ad_q;   // |delta| * dpt
	logic phase_q;          // in ST_DPT, 0: launch |delta|*dpt, 1: launch divide

	// in ST_MUL the next product is launched as the current one lands
	logic [1:0] mul_sel;
	assign mul_sel = (state_q == ST_MUL) ? term_q + 2'd1 : term_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_DPT) begin
			mul_a = PAW'($signed({1'b0, (delta_q[TW-1] ? -delta_q : delta_q)}));
			mul_b = dpt_q;
		end else begin
			case (mul_sel)
				2'd0: begin
					mul_a = PAW'(err_q);
					mul_b = gain_p_q;
				end
				2'd1: begin
					mul_a = PAW'(sum_q);
					mul_b = gain_i_q;
				end
				default: begin
					mul_a = PAW'(err_q) - PAW'(perr_q[w_q]);
					mul_b = gain_d_q;
				end
			endcase
		end
	end

	dwpid_mac #(.AW(PAW), .BW(16)) u_mac (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_p)
	);

	logic [DW-1:0] num_k;
	assign num_k = (DW'(ad_q) << 10) - (DW'(ad_q) << 4) - (DW'(ad_q) << 3);
	assign div_num = num_k;

	dwpid_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(DW'({dt_q, 8'd0})), .ctl(div_ctl), .quo(div_quo)
	);

	// speed, error, saturated sum
	logic signed [DW:0] speed_s, err_w;
	logic signed [33:0] sum_w;
	logic signed [15:0] err_sat;
	logic signed [31:0] sum_sat;
	assign speed_s = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign err_w   = (DW+1)'(target_q) - speed_s;
	assign err_sat = (err_w > 32767) ? 16'sh7fff :
		(err_w < -32768) ? 16'sh8000 : err_w[15:0];
	assign sum_w   = 34'(esum_q[w_q]) + 34'(err_sat);
	assign sum_sat = (sum_w > 34'sh07fffffff) ? 32'sh7fffffff :
		(sum_w < -34'sh080000000) ? 32'sh80000000 : sum_w[31:0];

	// rounding and power update
	logic signed [PAW+15:0] yr;
	logic signed [PAW+3:0] stepv;
	logic signed [PAW+4:0] pw;
	logic signed [15:0] pw_sat;
	assign yr    = acc_q + 2048;
	assign stepv = yr[PAW+15:12];   // floor division == round half up
	assign pw    = (PAW+5)'(power_q[w_q]) + (PAW+5)'(stepv);
	assign pw_sat = (pw > dwpid_pkg::POWER_MAX) ? 16'(dwpid_pkg::POWER_MAX) :
		(pw < -dwpid_pkg::POWER_MAX) ? -16'(dwpid_pkg::POWER_MAX) : pw[15:0];

	// distance check and dt
	logic [TICK_BITS:0] tsum;
	logic [TICK_BITS-1:0] in_l, in_r;
	logic [31:0] in_dt;
	assign in_l  = TICK_BITS'(left_ticks);
	assign in_r  = TICK_BITS'(right_ticks);
	assign tsum  = {1'b0, in_l} + {1'b0, in_r};
	assign in_dt = time_ms - ptime_q;

	logic signed [15:0] pl, pr;
	always_comb begin
		pl = power_q[0];
		pr = (WHEELS > 1) ? power_q[WHEELS > 1 ? 1 : 0] : 16'sd0;
	end

	assign mul_start = (state_q == ST_IDLE && 1'b0) ||
		(state_q == ST_DPT && !phase_q) ||
		(state_q == ST_ERR) ||
		(state_q == ST_MUL && mul_done && term_q != 2'd2);
	assign div_start = (state_q == ST_DPT && phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_full_q <= 1'b0;
			target_q <= dwpid_pkg::TARGET_RST;
			gain_p_q <= dwpid_pkg::GAIN_P_RST;
			gain_i_q <= dwpid_pkg::GAIN_I_RST;
			gain_d_q <= dwpid_pkg::GAIN_D_RST;
			dpt_q    <= dwpid_pkg::DPT_RST;
			limit_q  <= '0;
			skid_q   <= 1'b0;
			ptime_q  <= '0;
			phase_q  <= 1'b0;
			for (int i = 0; i < WHEELS; i++) begin
				power_q[i]  <= '0;
				perr_q[i]   <= '0;
				esum_q[i]   <= '0;
				pticks_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dwpid_pkg::REG_TARGET: target_q <= cfg_data[15:0];
					dwpid_pkg::REG_GAIN_P: gain_p_q <= cfg_data[15:0];
					dwpid_pkg::REG_GAIN_I: gain_i_q <= cfg_data[15:0];
					dwpid_pkg::REG_GAIN_D: gain_d_q <= cfg_data[15:0];
					dwpid_pkg::REG_DPT:    dpt_q    <= cfg_data[15:0];
					dwpid_pkg::REG_LIMIT:  limit_q  <= cfg_data;
					dwpid_pkg::REG_SKID:   skid_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_xfer)
				out_full_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ticks_q[0] <= in_l;
						ticks_q[1] <= in_r;
						now_q <= time_ms;
						dt_q  <= in_dt;
						w_q   <= '0;
						fault_q <= 1'b0;
						done_q  <= 1'b0;
						if (!action) begin
							// start of run
							for (int i = 0; i < WHEELS; i++) begin
								power_q[i]  <= '0;
								perr_q[i]   <= '0;
								esum_q[i]   <= '0;
								pticks_q[i] <= '0;
							end
							ptime_q <= time_ms;
							ldrv_q <= '0;
							rdrv_q <= '0;
							out_full_q <= 1'b1;
						end else if (tsum >= {limit_q, 1'b0}) begin
							for (int i = 0; i < WHEELS; i++)
								power_q[i] <= '0;
							ldrv_q <= '0;
							rdrv_q <= '0;
							done_q <= 1'b1;
							out_full_q <= 1'b1;
						end else if (in_dt == '0) begin
							fault_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							delta_q <= $signed({1'b0, in_l}) - $signed({1'b0, pticks_q[0]});
							phase_q <= 1'b0;
							state_q <= ST_DPT;
						end
					end
				end
				ST_DPT: begin
					// phase 0 launches |delta|*dpt, phase 1 launches the divide
					if (!phase_q) begin
						neg_q   <= delta_q[TW-1];
						phase_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						phase_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (phase_q && mul_done) begin
						ad_q    <= mul_p[TW+15:0];
						state_q <= ST_DPT;
					end else if (!phase_q && div_ctl.done) begin
						err_q  <= err_sat;
						sum_q  <= sum_sat;
						term_q <= 2'd0;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					acc_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						acc_q <= acc_q + mul_p;
						if (term_q == 2'd2)
							state_q <= ST_UPD;
						term_q <= term_q + 2'd1;
					end
				end
				ST_UPD: begin
					power_q[w_q]  <= pw_sat;
					esum_q[w_q]   <= sum_q;
					perr_q[w_q]   <= err_q;
					pticks_q[w_q] <= ticks_q[w_q[0]];
					if (32'(w_q) == WHEELS - 1 || w_q == WIX'(1)) begin
						ptime_q <= now_q;
						state_q <= ST_OUT;
					end else begin
						w_q <= w_q + 1'b1;
						delta_q <= $signed({1'b0, ticks_q[1]}) -
							$signed({1'b0, pticks_q[WHEELS > 1 ? 1 : 0]});
						phase_q <= 1'b0;
						state_q <= ST_DPT;
					end
				end
				ST_OUT: begin
					ldrv_q <= skid_q ? pl : -pl;
					rdrv_q <= skid_q ? -pr : pr;
					out_full_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no input is accepted while a result is pending
	a_no_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_full_q |-> in_stall) else $error("input accepted while result pending");
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (left_drive == 0 && right_drive == 0))
		else $error("done result with nonzero drive");
	a_done_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && time_fault)) else $error("done and fault together");
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_drive <= 25600 && left_drive >= -25600))
		else $error("left drive out of range");
endmodule

// ----- sv/dwpid_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dwpid_div #(
	parameter int W = dwpid_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output dwpid_pkg::div_ctl_t ctl,
	output logic [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quo       = quo_q;
endmodule

// ----- sv/dwpid_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwpid_mac: shift-add multiplier
// Signed by unsigned product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dwpid_mac #(
	parameter int AW = 34,
	parameter int BW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [AW-1:0]     a,
	input  logic [BW-1:0]            b,
	output logic                     done,
	output logic signed [AW+BW-1:0]  prod
);
	localparam int CW = $clog2(BW + 1);
	logic signed [AW+BW-1:0] acc_q, a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= (AW+BW)'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for dual_wheel_pid_speed_drive
// Drives start and sample transfers with random gaps and output stalls,
// predicts every result with an in-bench copy of the speed loop, and
// compares each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
	localparam int  ITEM_GOAL   = 1950;
	localparam int  DRAIN_WAIT  = 400;         // a bit over one slow sample
	localparam longint CYC_LIMIT = 64'd6000000; // several times slowest run
	// index with no register behind it
	localparam logic [dwpid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic        action;
		logic [23:0] left_ticks;
		logic [23:0] right_ticks;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic [15:0] left_drive;
		logic [15:0] right_drive;
		logic        done_res;
		logic        time_fault;
	} drive_t;

	// ------------------------------------------------------------------ DUT io
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [23:0] left_ticks = '0;
	logic [23:0] right_ticks = '0;
	logic [31:0] time_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic done_res;
	logic time_fault;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dwpid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	dual_wheel_pid_speed_drive i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .left_ticks(left_ticks), .right_ticks(right_ticks),
		.time_ms(time_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_drive(left_drive), .right_drive(right_drive),
		.done_res(done_res), .time_fault(time_fault),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------ predictor state
	// Register copies, updated when a config transfer is taken.
	logic signed [15:0] m_target;
	logic [15:0] m_gain_p, m_gain_i, m_gain_d, m_dpt;
	logic [23:0] m_limit;
	logic m_skid;
	// Wheel state, index 0 left, 1 right.
	logic signed [15:0] m_power [2];
	logic signed [15:0] m_prev_err [2];
	logic signed [31:0] m_err_sum [2];
	logic [23:0] m_prev_ticks [2];
	logic [31:0] m_prev_time;

	drive_t expected_drives [$];

	int n_sent = 0, n_checked = 0, n_errors = 0;
	int n_done = 0, n_fault = 0, n_starts = 0;
	bit idle_on = 1'b1;    // gaps and stalls allowed in this stretch
	longint cycles = 0;

	function automatic longint clip(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	task automatic clear_wheels();
		for (int w = 0; w < 2; w++) begin
			m_power[w] = '0;
			m_prev_err[w] = '0;
			m_err_sum[w] = '0;
			m_prev_ticks[w] = '0;
		end
		m_prev_time = '0;
	endtask

	// One accepted transfer in, one predicted result out.
	task automatic predict_drive(input sample_t s, output drive_t r);
		logic [23:0] tk [2];
		logic [31:0] dt;
		longint delta, speed, err, sum, acc, lft, rgt;
		tk[0] = s.left_ticks;
		tk[1] = s.right_ticks;
		r = '0;
		if (!s.action) begin
			clear_wheels();
			m_prev_time = s.time_ms;
			return;
		end
		// distance reached wins over everything but a start
		if (longint'(tk[0]) + longint'(tk[1]) >= 2 * longint'(m_limit)) begin
			m_power[0] = '0;
			m_power[1] = '0;
			r.done_res = 1'b1;
			return;
		end
		dt = s.time_ms - m_prev_time;
		if (dt == 0) begin
			r.time_fault = 1'b1;
		end else begin
			for (int w = 0; w < 2; w++) begin
				delta = longint'(tk[w]) - longint'(m_prev_ticks[w]);
				speed = (delta * longint'(m_dpt) * 1000) / (longint'(dt) * 256);
				err = clip(longint'(m_target) - speed, -32768, 32767);
				sum = clip(longint'(m_err_sum[w]) + err, -64'sd2147483648, 64'sd2147483647);
				acc = err * longint'(m_gain_p) + sum * longint'(m_gain_i)
					+ (err - longint'(m_prev_err[w])) * longint'(m_gain_d);
				// floor((acc+2048)/4096): nearest, ties up
				m_power[w] = 16'(clip(longint'(m_power[w]) + ((acc + 2048) >>> 12),
					-dwpid_pkg::POWER_MAX, dwpid_pkg::POWER_MAX));
				m_err_sum[w] = 32'(sum);
				m_prev_err[w] = 16'(err);
				m_prev_ticks[w] = tk[w];
			end
			m_prev_time = s.time_ms;
		end
		lft = m_power[0];
		rgt = m_power[1];
		if (m_skid)
			rgt = -rgt;
		else
			lft = -lft;
		r.left_drive = 16'(lft);
		r.right_drive = 16'(rgt);
	endtask

	// --------------------------------------------------------------- idling
	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if (!idle_on)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 150);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// -------------------------------------------------------- result check
	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		n_errors++;
		$display("mismatch #%0d at result %0d: %s got %0h want %0h",
			n_errors, n_checked, what, got, want);
	endtask

	always @(posedge clk) begin
		drive_t want;
		if (out_valid && !out_stall) begin
			if (expected_drives.size() == 0) begin
				report_mismatch("unexpected result", 16'(left_drive), 16'h0);
			end else begin
				want = expected_drives.pop_front();
				if (left_drive !== want.left_drive)
					report_mismatch("left_drive", left_drive, want.left_drive);
				if (right_drive !== want.right_drive)
					report_mismatch("right_drive", right_drive, want.right_drive);
				if (done_res !== want.done_res)
					report_mismatch("done_res", 16'(done_res), 16'(want.done_res));
				if (time_fault !== want.time_fault)
					report_mismatch("time_fault", 16'(time_fault), 16'(want.time_fault));
			end
			n_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycles, expected_drives.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ----------------------------------------------------- shared drivers
	// Inputs change at the falling edge; the transfer is seen at the rising
	// edge with the values from before that edge.
	task automatic send_item(input sample_t s);
		drive_t r;
		int gap;
		action <= s.action;
		left_ticks <= s.left_ticks;
		right_ticks <= s.right_ticks;
		time_ms <= s.time_ms;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_drive(s, r);
		expected_drives.push_back(r);
		n_sent++;
		if (!s.action) n_starts++;
		if (r.done_res) n_done++;
		if (r.time_fault) n_fault++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_drives.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [dwpid_pkg::CFG_IDX_W-1:0] idx,
		input logic [23:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dwpid_pkg::REG_TARGET: m_target = val[15:0];
			dwpid_pkg::REG_GAIN_P: m_gain_p = val[15:0];
			dwpid_pkg::REG_GAIN_I: m_gain_i = val[15:0];
			dwpid_pkg::REG_GAIN_D: m_gain_d = val[15:0];
			dwpid_pkg::REG_DPT:    m_dpt = val[15:0];
			dwpid_pkg::REG_LIMIT:  m_limit = val;
			dwpid_pkg::REG_SKID:   m_skid = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_all(input logic [15:0] tgt, input logic [15:0] gp,
		input logic [15:0] gi, input logic [15:0] gd, input logic [15:0] dpt,
		input logic [23:0] lim, input logic skid);
		wait_idle();
		write_reg(dwpid_pkg::REG_TARGET, {8'h0, tgt});
		write_reg(dwpid_pkg::REG_GAIN_P, {8'h0, gp});
		write_reg(dwpid_pkg::REG_GAIN_I, {8'h0, gi});
		write_reg(dwpid_pkg::REG_GAIN_D, {8'h0, gd});
		write_reg(dwpid_pkg::REG_DPT, {8'h0, dpt});
		write_reg(dwpid_pkg::REG_LIMIT, lim);
		write_reg(dwpid_pkg::REG_SKID, {23'h0, skid});
	endtask

	function automatic sample_t mk(input logic a, input logic [23:0] l,
		input logic [23:0] r, input logic [31:0] t);
		sample_t s;
		s.action = a;
		s.left_ticks = l;
		s.right_ticks = r;
		s.time_ms = t;
		return s;
	endfunction

	// ----------------------------------------------------------- the tests
	// Register defaults out of reset: limit zero, so every sample is done.
	task automatic test_defaults();
		send_item(mk(1'b1, 24'd0, 24'd0, 32'd0));
		send_item(mk(1'b0, 24'd0, 24'd0, 32'd1000));
		send_item(mk(1'b1, 24'd40, 24'd44, 32'd1200));
	endtask

	// Extremes of every field and each special case of the control loop.
	task automatic test_directed();
		set_all(16'd2560, 16'd3686, 16'd369, 16'd1638, 16'd1024, 24'hFFFFFF, 1'b0);
		send_item(mk(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FF00));
		send_item(mk(1'b1, 24'd20, 24'd22, 32'hFFFF_FF00));     // zero elapsed
		send_item(mk(1'b1, 24'd20, 24'd22, 32'h0000_0010));     // time wraps
		send_item(mk(1'b1, 24'd60, 24'd90, 32'h0000_00D8));
		send_item(mk(1'b1, 24'd30, 24'd10, 32'h0000_01A0));     // counts go back
		send_item(mk(1'b1, 24'd30, 24'd10, 32'h0000_01A0));     // held powers
		send_item(mk(1'b1, 24'hFFFFFE, 24'd0, 32'h0000_01A1));  // huge jump, 1 ms
		send_item(mk(1'b1, 24'd0, 24'hFFFFFE, 32'hFFFF_FFFF));  // huge dt
		// saturating gains and targets drive power and sums to the rails
		set_all(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
		send_item(mk(1'b0, 24'd0, 24'd0, 32'd0));
		for (int k = 1; k <= 4; k++)
			send_item(mk(1'b1, 24'd0, 24'd0, 32'(k * 200)));
		set_all(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b1);
		send_item(mk(1'b1, 24'd5, 24'd5, 32'd1000));
		wait_idle();
		write_reg(dwpid_pkg::REG_GAIN_P, 24'h00FFFF);
		write_reg(dwpid_pkg::REG_GAIN_D, 24'h00FFFF);
		send_item(mk(1'b1, 24'd9, 24'd9, 32'd1200));
		send_item(mk(1'b1, 24'd9, 24'd9, 32'd1400));
		// distance reached: one short of the boundary, exact, then one short again
		set_all(16'd2560, 16'd3686, 16'd369, 16'd1638, 16'd1024, 24'd100, 1'b0);
		send_item(mk(1'b1, 24'd99, 24'd100, 32'd1600));
		send_item(mk(1'b1, 24'd100, 24'd100, 32'd1800));
		send_item(mk(1'b1, 24'd100, 24'd99, 32'd2000));
		wait_idle();
		write_reg(REG_UNUSED, 24'hA5A5A5);      // unmapped index, ignored
		send_item(mk(1'b1, 24'd101, 24'd99, 32'd2200));
	endtask

	function automatic logic [15:0] pick_reg16(input logic [15:0] typical);
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: return 16'(typical + $urandom_range(0, 512) - 256);
		endcase
	endfunction

	// Runs of start then samples with steady time and counts, plus noise.
	task automatic test_random_runs();
		logic [15:0] tgt;
		logic [23:0] lim, lt, rt;
		logic [31:0] t;
		int run_len, phase = 0;
		sample_t s;
		while (n_sent < ITEM_GOAL) begin
			phase++;
			idle_on = (phase % 5 != 3);
			case ($urandom_range(0, 7))
				0: tgt = 16'h8000;
				1: tgt = 16'h7FFF;
				2: tgt = 16'($urandom);
				default: tgt = 16'($urandom_range(0, 6000)) - 16'd1000;
			endcase
			case ($urandom_range(0, 7))
				0: lim = 24'd0;
				1: lim = 24'hFFFFFF;
				default: lim = 24'($urandom_range(200, 12000));
			endcase
			set_all(tgt, pick_reg16(16'd3686), pick_reg16(16'd369),
				pick_reg16(16'd1638), pick_reg16(16'd1024), lim, 1'($urandom));
			t = $urandom;
			lt = '0;
			rt = '0;
			send_item(mk(1'b0, 24'($urandom), 24'($urandom), t));
			run_len = $urandom_range(15, 70);
			for (int k = 0; k < run_len && n_sent < ITEM_GOAL; k++) begin
				case ($urandom_range(0, 19))
					0: s = mk(1'($urandom), 24'($urandom), 24'($urandom), $urandom);
					1: s = mk(1'b1, lt, rt, t);                   // zero elapsed
					2: begin                                    // counts slip back
						lt = lt - 24'($urandom_range(0, 40));
						rt = rt - 24'($urandom_range(0, 40));
						t = t + 32'($urandom_range(1, 400));
						s = mk(1'b1, lt, rt, t);
					end
					default: begin
						lt = lt + 24'($urandom_range(0, 300));
						rt = rt + 24'($urandom_range(0, 300));
						t = t + 32'($urandom_range(1, 400));
						s = mk(1'b1, lt, rt, t);
					end
				endcase
				send_item(s);
				if (s.time_ms != t)
					t = s.time_ms;      // noise may have moved the baseline
				// hold off once in a while until the block has drained
				if ($urandom_range(0, 299) == 0 || (phase == 2 && k == 5))
					wait_idle();
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		m_target = dwpid_pkg::TARGET_RST;
		m_gain_p = dwpid_pkg::GAIN_P_RST;
		m_gain_i = dwpid_pkg::GAIN_I_RST;
		m_gain_d = dwpid_pkg::GAIN_D_RST;
		m_dpt = dwpid_pkg::DPT_RST;
		m_limit = '0;
		m_skid = 1'b0;
		clear_wheels();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_defaults();
		test_directed();
		test_random_runs();

		wait_idle();
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("sent %0d items (%0d starts), checked %0d results", n_sent, n_starts,
			n_checked);
		$display("distance-done results %0d, zero-elapsed faults %0d, mismatches %0d",
			n_done, n_fault, n_errors);
		if (n_errors == 0 && expected_drives.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ----- files.f -----
sv/dwpid_pkg.sv
sv/dwpid_div.sv
sv/dwpid_mac.sv
sv/dual_wheel_pid_speed_drive.sv
tb/sv/tb_top.sv
